// ===== rtl/dke_pkg.sv =====
// Package for the rolling 2-bit k-mer extractor.
// Holds the payload and queue types, register indexes, mode codes and the
// base classification function. No dependencies.
`default_nettype none

package dke_pkg;

    // Field widths
    localparam int CODE_W     = 32;
    localparam int TAG_W      = 16;
    localparam int CHAR_W     = 8;
    localparam int KLEN_W     = 5;
    localparam int MODE_W     = 2;
    localparam int RUN_W      = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Widest k-mer that fits the code field, and default parameter value
    localparam int CODE_BASES = 16;
    localparam int MAX_K_DEF  = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RUN_W-1:0]  RUN_MAX    = 5'd31;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_TAG     = 2'd2;

    // Mode codes; the spare code behaves as forward
    localparam logic [MODE_W-1:0] MODE_FWD_ALL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RC_ALL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FWD_STEP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // Lower-case ASCII letters; OR-ing the case bit folds upper case onto them
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C   = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G   = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T   = 8'h74;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic              last_in_sequence;
    } dke_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] kmer_code;
        logic [TAG_W-1:0]  kmer_tag;
    } dke_out_t;

    // Classified base as it travels from front to back
    typedef struct packed {
        logic       base_ok;
        logic [1:0] code;
        logic       last;
    } dke_item_t;

    typedef struct packed {
        logic [KLEN_W-1:0] kmer_length;
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  sequence_tag;
    } dke_cfg_t;

    // Map an ASCII character to a base code, flag anything else
    function automatic dke_item_t classify(input dke_in_t item);
        dke_item_t         res;
        logic [CHAR_W-1:0] folded;
        folded      = item.base_char | CASE_BIT;
        res.last    = item.last_in_sequence;
        res.base_ok = 1'b1;
        res.code    = BASE_A;
        unique case (folded)
            CHAR_A:  res.code = BASE_A;
            CHAR_C:  res.code = BASE_C;
            CHAR_G:  res.code = BASE_G;
            CHAR_T:  res.code = BASE_T;
            default: res.base_ok = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dna_kmer_extractor_unit.sv =====
// Rolling 2-bit k-mer extractor, top level.
// Usage:
//   in_valid/in_ready/in_item carry one ASCII character and an end-of-sequence
//   flag per transaction. out_valid/out_ready/out_item carry one k-mer code
//   (low 2k bits, A0 C1 G2 T3) with the sequence tag. A character may yield
//   no result (invalid base, short run, homopolymer window).
//   cfg_we/cfg_index/cfg_data write k-mer length (0), mode (1) and sequence
//   tag (2), one register per write; write only while no transaction is in flight.
// Path: an accepted input transaction passes the front register, a queue slot
//   and the result register in that order; the rolling codes and run count
//   update at the edge that loads the result register.
// Throughput: one character per cycle while out_ready is high; set by the
//   combinational roll-and-compare in the back part, which pops one queue
//   entry per cycle.
// Reset: clears the rolling codes, run count, queue and result register;
//   k-mer length returns to 16, mode to forward, tag to 0.
// Stall: while out_ready is low the result register holds; the queue and the
//   front register absorb up to three more characters, then in_ready drops.
// Depends on dke_pkg, dke_front, dke_queue, dke_back, dke_cfg_regs.
`default_nettype none

module dna_kmer_extractor_unit
    import dke_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dke_in_t              in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dke_out_t                  out_item,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    dke_cfg_t  cfg;
    logic      push;
    dke_item_t push_item;
    logic      queue_full;
    logic      q_valid;
    dke_item_t q_item;
    logic      pop;

    dke_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dke_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    dke_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    dke_back #(
        .MAX_K (MAX_K)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // An all-A window is a homopolymer, so a zero code never leaves
    a_no_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.kmer_code != '0))
        else $error("zero k-mer code emitted");

    // A full queue always has an entry to pop
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> q_valid)
        else $error("queue full but empty");

    // Only a full queue makes the front refuse input
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> queue_full)
        else $error("input refused without back-pressure");

endmodule

`default_nettype wire

// ===== rtl/dke_front.sv =====
// Front stage of the k-mer extractor: accepts characters and classifies them.
// Depends on dke_pkg.
`default_nettype none

module dke_front
    import dke_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dke_in_t   in_item,
    output logic           push,
    output dke_item_t      push_item,
    input  wire logic      queue_full
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    dke_item_t stage_item_reg;

    // Take a new transaction when the stage is empty or drains this cycle
    assign push     = stage_valid_reg && !queue_full;
    assign in_ready = !stage_valid_reg || !queue_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Hold the classified base in the stage register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= classify(in_item);
        end
    end

    assign push_item = stage_item_reg;

endmodule

`default_nettype wire

// ===== rtl/dke_queue.sv =====
// Short queue between the front and back parts of the k-mer extractor.
// Depends on dke_pkg.
`default_nettype none

module dke_queue
    import dke_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dke_item_t push_item,
    output logic           full,
    output logic           q_valid,
    output dke_item_t      q_item,
    input  wire logic      pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    dke_item_t        slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dke_back.sv =====
// Back part of the k-mer extractor: rolls the forward and reverse-complement
// codes, filters homopolymers and drives the result register. Depends on dke_pkg.
`default_nettype none

module dke_back
    import dke_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dke_cfg_t  cfg,
    input  wire logic      q_valid,
    input  wire dke_item_t q_item,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dke_out_t       out_item
);

    localparam int K_LIM_INT = (MAX_K < CODE_BASES) ? MAX_K : CODE_BASES;
    localparam logic [KLEN_W-1:0] K_LIM = KLEN_W'(K_LIM_INT);

    logic [CODE_W-1:0] fwd_reg;
    logic [CODE_W-1:0] fwd_next;
    logic [CODE_W-1:0] rc_reg;
    logic [CODE_W-1:0] rc_next;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    dke_out_t          out_item_reg;

    logic [KLEN_W-1:0] k_eff;
    logic [MODE_W-1:0] mode_eff;
    logic [CODE_W-1:0] mask;
    logic [5:0]        rc_shift;
    logic [CODE_W-1:0] rc_shifted;
    logic [CODE_W-1:0] fwd_roll;
    logic [RUN_W-1:0]  run_inc;
    logic [CODE_W-1:0] window;
    logic              homopolymer;
    logic              full_window;
    logic              emit;

    // Clamp length and fold the spare mode onto forward
    always_comb
    begin
        if (cfg.kmer_length == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (cfg.kmer_length > K_LIM)
        begin
            k_eff = K_LIM;
        end
        else
        begin
            k_eff = cfg.kmer_length;
        end
        mode_eff = (cfg.mode == MODE_SPARE) ? MODE_FWD_ALL : cfg.mode;
    end

    assign mask     = {CODE_W{1'b1}} >> (6'd32 - {k_eff, 1'b0});
    assign rc_shift = {k_eff - 1'b1, 1'b0};

    // Roll both codes and count the run
    always_comb
    begin
        fwd_roll    = {fwd_reg[CODE_W-3:0], q_item.code};
        rc_shifted  = (rc_reg >> 2) | ({{(CODE_W-2){1'b0}}, ~q_item.code} << rc_shift);
        run_inc     = (run_reg < RUN_MAX) ? run_reg + 1'b1 : run_reg;
        full_window = q_item.base_ok && (run_inc >= k_eff);
        window      = ((mode_eff == MODE_RC_ALL) ? rc_shifted : fwd_roll) & mask;
        homopolymer = (window == ({(CODE_W/2){window[1:0]}} & mask));
        emit        = full_window && !homopolymer;
    end

    // Update state on each pop; end of sequence wins
    always_comb
    begin
        fwd_next = fwd_reg;
        rc_next  = rc_reg;
        run_next = run_reg;
        if (q_item.base_ok)
        begin
            fwd_next = fwd_roll;
            rc_next  = rc_shifted;
            run_next = (full_window && mode_eff == MODE_FWD_STEP) ? '0 : run_inc;
        end
        else
        begin
            run_next = '0;
        end
        if (q_item.last)
        begin
            fwd_next = '0;
            rc_next  = '0;
            run_next = '0;
        end
    end

    // Pop when the result register is free or drains now
    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            rc_reg        <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                fwd_reg <= fwd_next;
                rc_reg  <= rc_next;
                run_reg <= run_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_item_reg.kmer_code <= window;
            out_item_reg.kmer_tag  <= cfg.sequence_tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/dke_queue_dummy_guard.sv =====
// Configuration register file of the k-mer extractor.
// Depends on dke_pkg.
`default_nettype none

module dke_cfg_regs
    import dke_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output dke_cfg_t                  cfg
);

    dke_cfg_t cfg_reg;
    dke_cfg_t cfg_next;

    // Decode the write index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KMER_LENGTH: cfg_next.kmer_length  = cfg_data[KLEN_W-1:0];
                REG_MODE:        cfg_next.mode         = cfg_data[MODE_W-1:0];
                REG_SEQ_TAG:     cfg_next.sequence_tag = cfg_data[TAG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length  <= KLEN_RESET;
            cfg_reg.mode         <= MODE_FWD_ALL;
            cfg_reg.sequence_tag <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== bench/dna_kmer_extractor_unit_test.sv =====
// Self-checking bench for dna_kmer_extractor_unit: a predictor of the rolling k-mer
// encoder checks every result against its own queue of expected k-mers.
// Depends on dke_pkg and dna_kmer_extractor_unit.
`timescale 1ns / 1ps

module dna_kmer_extractor_unit_test;
    import dke_pkg::*;

    // Widest window the block honors with its default parameter
    localparam int K_LIMIT = (MAX_K_DEF < CODE_BASES) ? MAX_K_DEF : CODE_BASES;
    localparam int PHASES = 20;
    localparam int PHASE_CHARS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    dke_in_t              in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    dke_out_t             out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_KMER_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor copy of registers and rolling state
    logic [KLEN_W-1:0] kmer_len_r = KLEN_RESET;
    logic [MODE_W-1:0] mode_r = MODE_FWD_ALL;
    logic [TAG_W-1:0]  tag_r = '0;
    logic [CODE_W-1:0] fwd_code = '0;
    logic [CODE_W-1:0] rc_code = '0;
    logic [RUN_W-1:0]  run_len = '0;

    dke_in_t     char_backlog[$];
    dke_out_t    kmer_expect_q[$];
    dke_out_t    kmer_want;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          calm_in;
    bit          calm_out;
    int          error_count = 0;

    dna_kmer_extractor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Roll one accepted character into the window and queue the k-mer it yields
    task automatic roll_base(input dke_in_t item);
        logic              is_base;
        logic [1:0]        code;
        logic [1:0]        comp;
        int unsigned       k;
        logic [MODE_W-1:0] m;
        logic [CODE_W-1:0] mask;
        logic [CODE_W-1:0] window;
        logic [CODE_W-1:0] repeated;
        dke_out_t          res;
        is_base = 1'b1;
        code = BASE_A;
        case (item.base_char)
            "A", "a": code = BASE_A;
            "C", "c": code = BASE_C;
            "G", "g": code = BASE_G;
            "T", "t": code = BASE_T;
            default:  is_base = 1'b0;
        endcase
        k = 32'(kmer_len_r);
        if (k == 0) k = 1;
        if (k > K_LIMIT) k = K_LIMIT;
        m = (mode_r == MODE_SPARE) ? MODE_FWD_ALL : mode_r;
        mask = (k >= 16) ? '1 : ((32'h1 << (2 * k)) - 32'h1);
        if (is_base)
        begin
            comp = code ^ 2'b11;
            fwd_code = {fwd_code[CODE_W-3:0], code};
            rc_code = (rc_code >> 2) | ({30'b0, comp} << (2 * (k - 1)));
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
            if (run_len >= k)
            begin
                window = ((m == MODE_RC_ALL) ? rc_code : fwd_code) & mask;
                repeated = {16{window[1:0]}} & mask;
                // Drop windows made of a single repeated base
                if (window != repeated)
                begin
                    res.kmer_code = window;
                    res.kmer_tag = tag_r;
                    kmer_expect_q.push_back(res);
                end
                if (m == MODE_FWD_STEP) run_len = '0;
            end
        end
        else
        begin
            run_len = '0;
        end
        if (item.last_in_sequence)
        begin
            fwd_code = '0;
            rc_code = '0;
            run_len = '0;
        end
    endtask

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [CHAR_W-1:0] base_letter(input logic [1:0] code, input bit lower);
        logic [CHAR_W-1:0] ch;
        case (code)
            BASE_A:  ch = "A";
            BASE_C:  ch = "C";
            BASE_G:  ch = "G";
            default: ch = "T";
        endcase
        return lower ? (ch | CASE_BIT) : ch;
    endfunction

    task automatic queue_char(input logic [CHAR_W-1:0] ch, input bit last);
        dke_in_t item;
        item.base_char = ch;
        item.last_in_sequence = last;
        char_backlog.push_back(item);
    endtask

    task automatic queue_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Hold until every character is sent and every k-mer has come, then let
    // the pipeline empty out
    task automatic settle();
        while (char_backlog.size() != 0 || in_valid || kmer_expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_KMER_LENGTH: kmer_len_r = data[KLEN_W-1:0];
            REG_MODE:        mode_r = data[MODE_W-1:0];
            REG_SEQ_TAG:     tag_r = data[TAG_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: present queued characters, predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready) roll_base(in_item);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (char_backlog.size() != 0)
                begin
                    in_item <= char_backlog.pop_front();
                    in_valid <= 1'b1;
                    gap_left = draw_wait(calm_in);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted k-mer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (kmer_expect_q.size() == 0)
                begin
                    $error("unexpected k-mer: kmer_code %h kmer_tag %h",
                           out_item.kmer_code, out_item.kmer_tag);
                    error_count++;
                end
                else
                begin
                    kmer_want = kmer_expect_q.pop_front();
                    if (out_item.kmer_code !== kmer_want.kmer_code)
                    begin
                        $error("kmer_code mismatch: expected %h, actual %h",
                               kmer_want.kmer_code, out_item.kmer_code);
                        error_count++;
                    end
                    if (out_item.kmer_tag !== kmer_want.kmer_tag)
                    begin
                        $error("kmer_tag mismatch: expected %h, actual %h",
                               kmer_want.kmer_tag, out_item.kmer_tag);
                        error_count++;
                    end
                end
                stall_left = draw_wait(calm_out);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed cases, then random phases under changing settings
    initial
    begin
        int unsigned       seg_kind;
        int unsigned       seg_len;
        int unsigned       n;
        logic [1:0]        streak_base;
        logic [CHAR_W-1:0] ch;
        logic [KLEN_W-1:0] k_pick;
        logic [MODE_W-1:0] m_pick;
        calm_in = 1'b0;
        calm_out = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Length zero acts as one, spare mode acts as forward: all suppressed
        write_reg(REG_KMER_LENGTH, 16'hFFE0);
        write_reg(REG_MODE, 16'hFFFF);
        write_reg(REG_SEQ_TAG, 16'hFFFF);
        @(negedge clk);
        queue_text("At", 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b1);
        settle();

        // Reverse complement, invalid character, homopolymer, end of sequence
        write_reg(REG_KMER_LENGTH, 16'd3);
        write_reg(REG_MODE, {14'b0, MODE_RC_ALL});
        write_reg(REG_SEQ_TAG, 16'h0000);
        @(negedge clk);
        queue_text("ACGTN", 1'b0);
        queue_text("aaaC", 1'b1);
        settle();

        // Non-overlapping windows restart the run, even when suppressed
        write_reg(REG_KMER_LENGTH, 16'd2);
        write_reg(REG_MODE, {14'b0, MODE_FWD_STEP});
        write_reg(REG_SEQ_TAG, 16'hA5C3);
        @(negedge clk);
        queue_text("GCTTgGA", 1'b1);
        settle();

        // Random phases; state carries across phase boundaries on purpose
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       k_pick = 5'd16;
                1:       k_pick = 5'd31;
                2:       k_pick = 5'd17;
                3:       k_pick = 5'd0;
                4:       k_pick = 5'd1;
                default: k_pick = ($urandom_range(0, 3) == 0) ?
                                  KLEN_W'($urandom_range(0, 31)) :
                                  KLEN_W'($urandom_range(2, 8));
            endcase
            m_pick = MODE_W'(p % 4);
            write_reg(REG_KMER_LENGTH, {11'($urandom), k_pick});
            write_reg(REG_MODE, {14'($urandom), m_pick});
            write_reg(REG_SEQ_TAG, (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom));
            calm_in = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            @(negedge clk);
            n = 0;
            while (n < PHASE_CHARS)
            begin
                seg_kind = $urandom_range(0, 9);
                streak_base = 2'($urandom_range(0, 3));
                seg_len = (seg_kind == 0) ? $urandom_range(1, 6) : $urandom_range(1, 45);
                for (int j = 0; j < seg_len; j++)
                begin
                    if (seg_kind == 0)
                    begin
                        // noise: any byte, any flag
                        queue_char(8'($urandom), $urandom_range(0, 3) == 0);
                    end
                    else
                    begin
                        if (seg_kind == 1 && $urandom_range(0, 9) != 0)
                            ch = base_letter(streak_base, 1'($urandom_range(0, 1)));
                        else if ($urandom_range(0, 29) == 0)
                            ch = 8'($urandom);
                        else
                            ch = base_letter(2'($urandom), 1'($urandom_range(0, 1)));
                        queue_char(ch, (j == seg_len - 1) && ($urandom_range(0, 3) != 0));
                    end
                end
                n += seg_len;
            end
            settle();
        end

        if (error_count == 0)
            $display("dna_kmer_extractor_unit_test passed");
        else
            $display("dna_kmer_extractor_unit_test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("dna_kmer_extractor_unit_test failed");
        $finish;
    end

endmodule
